FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, suspended while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Checked on every rising clock edge, including during reset.
`define ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

FILE: src/slir_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Sizes, operation and status codes, and the structs passed between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package slir_pkg;

	// Number of cells in the chain and width of one stored value.
	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;

	// Internal entry counter, able to hold CAPACITY itself.
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Widths of the result fields on the output stream; tdata is padded to bytes.
	localparam int COUNT_FIELD_W  = 5;
	localparam int STATUS_FIELD_W = 2;
	localparam int M_TDATA_W      = ((COUNT_FIELD_W + VALUE_WIDTH + 1 + 7) / 8) * 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [STATUS_FIELD_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Command broadcast to every cell in the chain.
	typedef struct packed {
		logic                   ins;
		logic                   rem;
		logic [VALUE_WIDTH-1:0] value;
	} slir_cmd_t;

	// What a cell shows to its neighbors.
	typedef struct packed {
		logic                   valid;
		logic                   lt;
		logic [VALUE_WIDTH-1:0] value;
	} slir_link_t;

endpackage

`default_nettype wire

FILE: src/slir_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it with the request value and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  slir_pkg::slir_cmd_t  cmd,
	input  slir_pkg::slir_link_t left,
	input  slir_pkg::slir_link_t right,
	input  logic                seen_in,
	output slir_pkg::slir_link_t link,
	output logic                seen_out
);
	import slir_pkg::*;

	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   eq;
	logic                   take_left;
	logic                   take_new;
	logic                   take_right;

	// Compare the held entry with the request value.
	assign link.valid = valid_q;
	assign link.lt    = valid_q && ($signed(entry_q) < $signed(cmd.value));
	assign link.value = entry_q;
	assign eq         = valid_q && (entry_q == cmd.value);

	// The first equal entry and everything above it move down on a remove.
	assign seen_out = seen_in | eq;

	// Entries not smaller than the value move up; the lowest of them takes it.
	assign take_new   = cmd.ins && !link.lt && left.lt;
	assign take_left  = cmd.ins && !link.lt && !left.lt;
	assign take_right = cmd.rem && seen_out;

	// Occupancy of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left.valid;
		end else if (take_right) begin
			valid_q <= right.valid;
		end
	end

	// Stored value.
	always_ff @(posedge clk) begin
		if (take_new) begin
			entry_q <= cmd.value;
		end else if (take_left) begin
			entry_q <= left.value;
		end else if (take_right) begin
			entry_q <= right.value;
		end
	end

endmodule

`default_nettype wire

FILE: src/sorted_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// Sorted list insert and remove
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
//
// Channel   Dir   tdata (low bit up)                        tuser
// s_axis    in    value[31:0]                               op
// m_axis    out   count[4:0] smallest[36:5] empty_res[37]   status
//
// One request is taken per cycle while the result register can be refilled;
// its result is registered and offered on the cycle after acceptance. The
// rate is set by the compare-and-shift in every cell and the found chain
// that runs through the cells for a remove.
// Reset clears all cell valid bits and the count at once; no clearing pass.
// s_axis_tready is high while the result register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_list_insert_remove_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [slir_pkg::VALUE_WIDTH-1:0] s_axis_tdata, // value
	input  logic                          s_axis_tuser, // op
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [slir_pkg::M_TDATA_W-1:0] m_axis_tdata, // count, smallest, empty_res
	output logic [slir_pkg::STATUS_FIELD_W-1:0] m_axis_tuser // status
);
	import slir_pkg::*;

	localparam int PAD_W = M_TDATA_W - COUNT_FIELD_W - VALUE_WIDTH - 1;

	logic                   s_acc;
	op_t                    op;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic                   full;
	logic                   found;
	status_t                status_d;
	logic [VALUE_WIDTH-1:0] small_d;
	slir_cmd_t              cmd;
	slir_link_t             links [CAPACITY];
	slir_link_t             lefts [CAPACITY];
	slir_link_t             rights [CAPACITY];
	logic                   seen [CAPACITY+1];
	logic [CAPACITY-1:0]    valid_vec;

	logic                   m_valid_q;
	status_t                m_status_q;
	logic [CNT_W-1:0]       m_count_q;
	logic [VALUE_WIDTH-1:0] m_small_q;
	logic                   m_empty_q;

	// Handshake: take a request while the result register can be refilled.
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser);

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = seen[CAPACITY];

	// Command broadcast to the cells; dropped requests change nothing.
	assign cmd.ins   = s_acc && (op == OP_INSERT) && !full;
	assign cmd.rem   = s_acc && (op == OP_REMOVE) && found;
	assign cmd.value = s_axis_tdata;

	// Chain of cells with boundary links at both ends.
	assign seen[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign lefts[gi] = '{valid: 1'b1, lt: 1'b1, value: s_axis_tdata};
			end else begin : g_mid
				assign lefts[gi] = links[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign rights[gi] = '{valid: 1'b0, lt: 1'b0, value: '0};
			end else begin : g_inner
				assign rights[gi] = links[gi+1];
			end
			assign valid_vec[gi] = links[gi].valid;

			slir_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.left     (lefts[gi]),
				.right    (rights[gi]),
				.seen_in  (seen[gi]),
				.link     (links[gi]),
				.seen_out (seen[gi+1])
			);
		end
	endgenerate

	// Status and next count for the request at the port.
	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		priority if (op == OP_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (count_q == '0) begin
			status_d = ST_EMPTY;
		end else if (!found) begin
			status_d = ST_NOT_FOUND;
		end else begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Smallest entry once the request has been applied.
	always_comb begin
		small_d = links[0].value;
		if (count_d == '0) begin
			small_d = '0;
		end else if (cmd.ins && !links[0].lt) begin
			small_d = s_axis_tdata;
		end else if (cmd.rem && seen[1]) begin
			small_d = links[1].value;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_acc) begin
			count_q <= count_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_status_q <= status_d;
			m_count_q  <= count_d;
			m_small_q  <= small_d;
			m_empty_q  <= (count_d == '0);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, m_empty_q, m_small_q, COUNT_FIELD_W'(m_count_q)};

	// Checks on the chain and the counter.
	`ASSERT_CLK(a_count_matches_cells, clk, arst_n, $countones(valid_vec) == 32'(count_q))
	`ASSERT_CLK(a_cells_fill_from_head, clk, arst_n, ((valid_vec + 1'b1) & valid_vec) == '0)
	`ASSERT_CLK(a_insert_grows, clk, arst_n, cmd.ins |=> (count_q == $past(count_q) + 1'b1))
	`ASSERT_CLK(a_empty_flag_status, clk, arst_n, (m_valid_q && m_status_q == ST_EMPTY) |-> m_empty_q)

endmodule

`default_nettype wire

FILE: dv/sorted_list_insert_remove_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list checker
// Watches the request and result streams and keeps its own ordered copy of
// the list. It compares every result, field by field, with the result
// predicted for the oldest open request.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_checker
	import slir_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [VALUE_WIDTH-1:0]    s_axis_tdata, // value
	input  logic                      s_axis_tuser, // op
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [M_TDATA_W-1:0]      m_axis_tdata, // count, smallest, empty_res
	input  logic [STATUS_FIELD_W-1:0] m_axis_tuser, // status
	output int                        fail_count,
	output int                        open_requests,
	output int                        results_seen,
	output int                        full_drops,
	output int                        misses,
	output int                        empty_removes,
	output int                        peak_fill
);

	typedef struct packed {
		status_t                  status;
		logic [COUNT_FIELD_W-1:0] count;
		logic [VALUE_WIDTH-1:0]   smallest;
		logic                     empty_res;
	} list_result_t;

	// Ascending copy of the list contents, and the results still owed.
	logic signed [VALUE_WIDTH-1:0] sorted_vals[$];
	list_result_t                  owed_results[$];

	// Applies one request to the ordered copy and returns the result it causes.
	function automatic list_result_t predict_list_op(op_t op, logic signed [VALUE_WIDTH-1:0] v);
		list_result_t r;
		int           pos;
		r.status = ST_OK;
		pos = 0;
		if (op == OP_INSERT) begin
			if (sorted_vals.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// An equal value goes in front of the entries equal to it.
				while (pos < sorted_vals.size() && sorted_vals[pos] < v)
					pos++;
				sorted_vals.insert(pos, v);
			end
		end else if (sorted_vals.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			while (pos < sorted_vals.size() && sorted_vals[pos] != v)
				pos++;
			if (pos == sorted_vals.size())
				r.status = ST_NOT_FOUND;
			else
				sorted_vals.delete(pos);
		end
		r.count = COUNT_FIELD_W'(sorted_vals.size());
		r.empty_res = (sorted_vals.size() == 0);
		if (r.empty_res)
			r.smallest = '0;
		else
			r.smallest = sorted_vals[0];
		return r;
	endfunction

	// Results are checked before the request of the same edge is predicted;
	// a result always belongs to a request taken on an earlier edge.
	always @(posedge clk) begin : watch
		list_result_t want;
		list_result_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status    = status_t'(m_axis_tuser);
				got.count     = m_axis_tdata[COUNT_FIELD_W-1:0];
				got.smallest  = m_axis_tdata[COUNT_FIELD_W +: VALUE_WIDTH];
				got.empty_res = m_axis_tdata[COUNT_FIELD_W + VALUE_WIDTH];
				results_seen++;
				if (owed_results.size() == 0) begin
					$display("%0t: result with no open request, status %0d count %0d",
						$time, got.status, got.count);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, got.status);
						fail_count++;
					end
					if (got.count !== want.count) begin
						$display("%0t: count expected %0d got %0d",
							$time, want.count, got.count);
						fail_count++;
					end
					if (got.smallest !== want.smallest) begin
						$display("%0t: smallest expected %0d got %0d",
							$time, $signed(want.smallest), $signed(got.smallest));
						fail_count++;
					end
					if (got.empty_res !== want.empty_res) begin
						$display("%0t: empty_res expected %0b got %0b",
							$time, want.empty_res, got.empty_res);
						fail_count++;
					end
					case (want.status)
						ST_FULL:      full_drops++;
						ST_NOT_FOUND: misses++;
						ST_EMPTY:     empty_removes++;
						default:      ;
					endcase
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				owed_results.push_back(predict_list_op(op_t'(s_axis_tuser), s_axis_tdata));
				if (sorted_vals.size() > peak_fill)
					peak_fill = sorted_vals.size();
			end
			open_requests = owed_results.size();
		end
	end

endmodule

FILE: dv/sorted_list_insert_remove_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list testbench
// Drives insert and remove requests into the sorted list, first a directed
// set and then random phases that fill, drain or mix, with random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top_tb;

	import slir_pkg::*;

	localparam int RANDOM_ITEMS   = 1400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 8;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [VALUE_WIDTH-1:0]    s_axis_tdata = '0; // value
	logic                      s_axis_tuser = 1'b0; // op
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]      m_axis_tdata; // count, smallest, empty_res
	logic [STATUS_FIELD_W-1:0] m_axis_tuser; // status

	int fail_count;
	int open_requests;
	int results_seen;
	int full_drops;
	int misses;
	int empty_removes;
	int peak_fill;

	int requests_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	// Values believed to be held, used to aim removes at present entries.
	logic [VALUE_WIDTH-1:0] live_vals[$];
	logic [VALUE_WIDTH-1:0] value_pool[4];

	sorted_list_insert_remove_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	sorted_list_insert_remove_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.open_requests (open_requests),
		.results_seen  (results_seen),
		.full_drops    (full_drops),
		.misses        (misses),
		.empty_removes (empty_removes),
		.peak_fill     (peak_fill)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] corner_value();
		case ($urandom_range(0, 6))
			0:       return 32'h8000_0000;
			1:       return 32'h8000_0001;
			2:       return 32'h7fff_ffff;
			3:       return 32'h7fff_fffe;
			4:       return 32'hffff_ffff;
			5:       return 32'h0000_0001;
			default: return 32'h0000_0000;
		endcase
	endfunction

	// Inserts lean on a small pool and on held values so duplicates are common.
	function automatic logic [VALUE_WIDTH-1:0] pick_insert_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return value_pool[$urandom_range(0, 3)];
		if (r < 50 && live_vals.size() != 0)
			return live_vals[$urandom_range(0, live_vals.size() - 1)];
		if (r < 60)
			return corner_value();
		return $urandom;
	endfunction

	// Removes mostly hit a held value; the rest are likely misses.
	function automatic logic [VALUE_WIDTH-1:0] pick_remove_value(int hit_pct);
		if (live_vals.size() != 0 && $urandom_range(0, 99) < hit_pct)
			return live_vals[$urandom_range(0, live_vals.size() - 1)];
		if ($urandom_range(0, 1) == 0)
			return value_pool[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	// Sends one request and returns at the edge where it is accepted.
	task automatic issue(op_t op, logic [VALUE_WIDTH-1:0] v);
		int   gap;
		int   idx;
		logic rdy;
		gap = calm ? 0 : idle_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= v;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		requests_sent++;
		if (op == OP_INSERT) begin
			if (live_vals.size() < CAPACITY)
				live_vals.push_back(v);
		end else begin
			idx = -1;
			foreach (live_vals[i])
				if (idx < 0 && live_vals[i] == v)
					idx = i;
			if (idx >= 0)
				live_vals.delete(idx);
		end
	endtask

	// Result side: ready by default, with random stalls outside calm phases.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 20)
				stall_left <= idle_len();
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results still open",
				$time, quiet_cycles, open_requests);
			$display("sorted_list_insert_remove_top_tb failed");
			$finish;
		end
	end

	initial begin
		int insert_pct;
		int hit_pct;
		int phase_len;
		int n_random;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: remove on an empty list, then fill with extremes and
		// duplicates (one equal to the head), overflow, miss and removes.
		issue(OP_REMOVE, 32'd5);
		issue(OP_INSERT, 32'h7fff_ffff);
		issue(OP_INSERT, 32'h8000_0000);
		issue(OP_INSERT, 32'h8000_0000);
		issue(OP_INSERT, 32'h0000_0000);
		issue(OP_INSERT, 32'hffff_ffff);
		issue(OP_INSERT, 32'h0000_0001);
		issue(OP_INSERT, 32'h0000_0000);
		issue(OP_INSERT, 32'h5555_5555);
		issue(OP_INSERT, 32'haaaa_aaaa);
		issue(OP_INSERT, 32'h7fff_ffff);
		repeat (6) issue(OP_INSERT, $urandom);
		issue(OP_INSERT, 32'd42);
		issue(OP_REMOVE, 32'h1234_5678);
		issue(OP_REMOVE, 32'h8000_0000);
		issue(OP_REMOVE, 32'h7fff_ffff);
		issue(OP_REMOVE, 32'h0000_0000);
		issue(OP_REMOVE, 32'hffff_ffff);

		// Random phases that fill, drain or mix.
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: begin
					insert_pct = 80;
					hit_pct = 70;
				end
				1: begin
					insert_pct = 20;
					hit_pct = 90;
				end
				default: begin
					insert_pct = 50;
					hit_pct = 60;
				end
			endcase
			calm = ($urandom_range(0, 4) == 0);
			foreach (value_pool[i])
				value_pool[i] = ($urandom_range(0, 3) == 0) ? corner_value() : $urandom;
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < insert_pct)
					issue(OP_INSERT, pick_insert_value());
				else
					issue(OP_REMOVE, pick_remove_value(hit_pct));
				n_random++;
			end
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		// Drain the remaining results, then let the block settle.
		@(posedge clk);
		while (open_requests != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d results, peak fill %0d of %0d entries.",
			requests_sent, results_seen, peak_fill, CAPACITY);
		$display("Dropped full inserts %0d, absent removes %0d, removes on empty %0d.",
			full_drops, misses, empty_removes);
		if (fail_count == 0)
			$display("sorted_list_insert_remove_top_tb passed");
		else
			$display("sorted_list_insert_remove_top_tb failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/slir_pkg.sv
src/slir_cell.sv
src/sorted_list_insert_remove_top.sv
dv/sorted_list_insert_remove_checker.sv
dv/sorted_list_insert_remove_top_tb.sv
